@@ design/sfpt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and sizes for the serial frame parser with timeout.
// Used by sfpt_ctrl, sfpt_datapath and serial_frame_parser_timeout_top.
package sfpt_pkg;

  localparam int MAX_PAYLOAD = 16;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0] START_MARKER_RST = 8'hAA;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'd1;

  localparam logic [1:0] ST_RECV     = 2'd0;
  localparam logic [1:0] ST_OK       = 2'd1;
  localparam logic [1:0] ST_SUM_ERR  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  typedef logic [3:0] dp_op_t;

  localparam dp_op_t OP_NOP       = 4'd0;
  localparam dp_op_t OP_IDLE      = 4'd1;
  localparam dp_op_t OP_START     = 4'd2;
  localparam dp_op_t OP_TIMEOUT   = 4'd3;
  localparam dp_op_t OP_CMD       = 4'd4;
  localparam dp_op_t OP_LEN       = 4'd5;
  localparam dp_op_t OP_LEN_BAD   = 4'd6;
  localparam dp_op_t OP_DATA      = 4'd7;
  localparam dp_op_t OP_SUM_EMPTY = 4'd8;
  localparam dp_op_t OP_SUM_FIRST = 4'd9;
  localparam dp_op_t OP_SUM_BAD   = 4'd10;
  localparam dp_op_t OP_READ_NEXT = 4'd11;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic timeout;
    logic marker_hit;
    logic len_big;
    logic len_byte_zero;
    logic fill_done;
    logic held_len_zero;
    logic held_len_one;
    logic rd_last;
    logic sum_match;
  } dp_stat_t;

endpackage

@@ design/serial_frame_parser_timeout_top.sv @@
`timescale 1ns / 1ps
// Top level of the serial frame parser with inter-byte timeout.
// Depends on sfpt_pkg, sfpt_ctrl and sfpt_datapath.
//
// Input stream: one beat per received byte (s_tdata[7:0] byte, [39:8] arrival
// time). Output stream: one beat per result; m_tuser carries the status
// (0 receiving, 1 frame ok, 2 checksum error, 3 timeout), m_tlast marks the
// final beat caused by one input beat.
// Frames are marker, command, length (0..MAX_PAYLOAD), payload, XOR checksum.
// Registers: index 0 gap limit (0 disables timeout), index 1 start marker.
// A result is registered and is on the output in the cycle after its input.
// Throughput: one input beat per cycle while the output is free; a good frame
// of N payload bytes yields N beats (one for an empty payload), read from the
// payload store at one beat per cycle unless stalled, holding off input.
// Reset (synchronous, active high): parser idle, gap limit 0, marker 0xAA,
// output empty. When the receiver stalls the output beat holds and s_tready
// drops, so no input is taken until the output register can be refilled.
module serial_frame_parser_timeout_top
  import sfpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // rx_byte[7:0], arrival_time[39:8]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // frame_command[7:0], frame_length[12:8],
                                          // payload_byte[20:13], payload_index[24:21]
  output logic [1:0]           m_tuser,   // status[1:0]
  output logic                 m_tlast    // last_of_run
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [7:0]       out_command;
  logic [LEN_W-1:0] out_length;
  logic [7:0]       out_pbyte;
  logic [IDX_W-1:0] out_index;

  sfpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfpt_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (s_tdata[7:0]),
    .arrival_time (s_tdata[39:8]),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_status   (m_tuser),
    .out_command  (out_command),
    .out_length   (out_length),
    .out_pbyte    (out_pbyte),
    .out_index    (out_index),
    .out_last     (m_tlast)
  );

  assign m_tdata = {7'd0, out_index, out_pbyte, out_length, out_command};

endmodule

@@ design/sfpt_ctrl.sv @@
`timescale 1ns / 1ps
// Frame parser controller: phase state machine and readout sequencing.
// Depends on sfpt_pkg; drives sfpt_datapath through dp_cmd_t.
module sfpt_ctrl
  import sfpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_SUM  = 3'd4;
  localparam logic [2:0] PH_READ = 3'd5;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic       accept;

  always_comb begin
    cmd.op     = OP_NOP;
    phase_next = phase;
    s_tready   = (phase != PH_READ) && stat.out_free;
    accept     = s_tvalid && s_tready;
    if (phase == PH_READ) begin
      if (stat.out_free) begin
        cmd.op = OP_READ_NEXT;
        if (stat.rd_last) begin
          phase_next = PH_IDLE;
        end
      end
    end else if (accept) begin
      if (phase != PH_IDLE && stat.timeout) begin
        cmd.op     = OP_TIMEOUT;
        phase_next = stat.marker_hit ? PH_CMD : PH_IDLE;
      end else begin
        case (phase)
          PH_IDLE: begin
            if (stat.marker_hit) begin
              cmd.op     = OP_START;
              phase_next = PH_CMD;
            end else begin
              cmd.op = OP_IDLE;
            end
          end
          PH_CMD: begin
            cmd.op     = OP_CMD;
            phase_next = PH_LEN;
          end
          PH_LEN: begin
            if (stat.len_big) begin
              cmd.op     = OP_LEN_BAD;
              phase_next = PH_IDLE;
            end else begin
              cmd.op     = OP_LEN;
              phase_next = stat.len_byte_zero ? PH_SUM : PH_DATA;
            end
          end
          PH_DATA: begin
            cmd.op = OP_DATA;
            if (stat.fill_done) begin
              phase_next = PH_SUM;
            end
          end
          PH_SUM: begin
            if (!stat.sum_match) begin
              cmd.op     = OP_SUM_BAD;
              phase_next = PH_IDLE;
            end else if (stat.held_len_zero) begin
              cmd.op     = OP_SUM_EMPTY;
              phase_next = PH_IDLE;
            end else begin
              cmd.op     = OP_SUM_FIRST;
              phase_next = stat.held_len_one ? PH_IDLE : PH_READ;
            end
          end
          default: begin
            cmd.op     = OP_LEN_BAD;
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

endmodule

@@ design/sfpt_datapath.sv @@
`timescale 1ns / 1ps
// Frame parser datapath: config registers, frame fields, payload store,
// checksum, gap check and the output register. Depends on sfpt_pkg.
module sfpt_datapath
  import sfpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [7:0]           rx_byte,
  input  logic [31:0]          arrival_time,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [7:0]           out_command,
  output logic [LEN_W-1:0]     out_length,
  output logic [7:0]           out_pbyte,
  output logic [IDX_W-1:0]     out_index,
  output logic                 out_last
);

  logic [31:0]      gap_limit;
  logic [7:0]       start_marker;
  logic [7:0]       held_command;
  logic [LEN_W-1:0] held_length;
  logic [LEN_W-1:0] fill;
  logic [7:0]       running_xor;
  logic [31:0]      last_time;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       store [MAX_PAYLOAD];
  logic [31:0]      gap;
  logic [IDX_W-1:0] rd_sel;

  assign gap    = arrival_time - last_time;
  assign rd_sel = (cmd.op == OP_SUM_FIRST) ? '0 : rd_idx;

  always_comb begin
    stat.out_free      = !out_valid || out_ready;
    stat.timeout       = (gap_limit != 32'd0) && (gap > gap_limit);
    stat.marker_hit    = (rx_byte == start_marker);
    stat.len_big       = (rx_byte > 8'(MAX_PAYLOAD));
    stat.len_byte_zero = (rx_byte == 8'd0);
    stat.fill_done     = (LEN_W'(fill + LEN_W'(1)) >= held_length);
    stat.held_len_zero = (held_length == '0);
    stat.held_len_one  = (held_length == LEN_W'(1));
    stat.rd_last       = (LEN_W'(LEN_W'(rd_idx) + LEN_W'(1)) == held_length);
    stat.sum_match     = (rx_byte == running_xor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit    <= 32'd0;
      start_marker <= START_MARKER_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GAP_LIMIT:    gap_limit    <= cfg_data;
        REG_START_MARKER: start_marker <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_command <= 8'd0;
      held_length  <= '0;
      fill         <= '0;
      running_xor  <= 8'd0;
      last_time    <= 32'd0;
      rd_idx       <= '0;
    end else begin
      case (cmd.op)
        OP_START: begin
          fill        <= '0;
          running_xor <= 8'd0;
          last_time   <= arrival_time;
        end
        OP_TIMEOUT: begin
          held_command <= 8'd0;
          held_length  <= '0;
          fill         <= '0;
          running_xor  <= 8'd0;
          last_time    <= arrival_time;
        end
        OP_CMD: begin
          held_command <= rx_byte;
          running_xor  <= running_xor ^ rx_byte;
          last_time    <= arrival_time;
        end
        OP_LEN: begin
          held_length <= rx_byte[LEN_W-1:0];
          running_xor <= running_xor ^ rx_byte;
          last_time   <= arrival_time;
        end
        OP_LEN_BAD, OP_SUM_BAD: begin
          held_command <= 8'd0;
          held_length  <= '0;
          fill         <= '0;
          running_xor  <= 8'd0;
          last_time    <= 32'd0;
        end
        OP_DATA: begin
          fill        <= LEN_W'(fill + LEN_W'(1));
          running_xor <= running_xor ^ rx_byte;
          last_time   <= arrival_time;
        end
        OP_SUM_EMPTY: begin
          last_time <= arrival_time;
        end
        OP_SUM_FIRST: begin
          last_time <= arrival_time;
          rd_idx    <= IDX_W'(1);
        end
        OP_READ_NEXT: begin
          rd_idx <= IDX_W'(rd_idx + IDX_W'(1));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DATA) begin
      store[fill[IDX_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op != OP_NOP) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op != OP_NOP) begin
      out_status  <= ST_RECV;
      out_command <= 8'd0;
      out_length  <= '0;
      out_pbyte   <= 8'd0;
      out_index   <= '0;
      out_last    <= 1'b1;
      case (cmd.op)
        OP_TIMEOUT: out_status <= ST_TIMEOUT;
        OP_SUM_BAD: out_status <= ST_SUM_ERR;
        OP_SUM_EMPTY: begin
          out_status  <= ST_OK;
          out_command <= held_command;
        end
        OP_SUM_FIRST, OP_READ_NEXT: begin
          out_status  <= ST_OK;
          out_command <= held_command;
          out_length  <= held_length;
          out_pbyte   <= store[rd_sel];
          out_index   <= rd_sel;
          out_last    <= (cmd.op == OP_SUM_FIRST) ? stat.held_len_one : stat.rd_last;
        end
        default: ;
      endcase
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_NOP) |-> (!out_valid || out_ready))
    else $error("result loaded over an unsent beat");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DATA) |-> (fill < held_length))
    else $error("payload write beyond frame length");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_READ_NEXT) |-> ((rd_idx != '0) && (LEN_W'(rd_idx) < held_length)))
    else $error("readout index out of frame");

  a_multi_not_last: assert property (@(posedge clk) disable iff (rst)
    ((cmd.op == OP_SUM_FIRST) && !stat.held_len_one) |=> (out_valid && !out_last))
    else $error("first beat of multi-byte frame marked last");

endmodule

@@ tb/sfpt_frame_checker.sv @@
`timescale 1ns / 1ps
// Checker for serial_frame_parser_timeout_top: follows register writes, predicts
// the result beats of every accepted byte beat and compares them in order.
// Depends on sfpt_pkg.
module sfpt_frame_checker
  import sfpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [39:0]          s_tdata,   // rx_byte[7:0], arrival_time[39:8]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [31:0]          m_tdata,   // frame_command[7:0], frame_length[12:8],
                                          // payload_byte[20:13], payload_index[24:21]
  input  logic [1:0]           m_tuser,   // status[1:0]
  input  logic                 m_tlast,
  output int                   errors,
  output int                   pending
);

  typedef enum logic [2:0] {PH_IDLE, PH_CMD, PH_LEN, PH_DATA, PH_SUM} parse_phase_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       command;
    logic [LEN_W-1:0] length;
    logic [7:0]       payload;
    logic [IDX_W-1:0] index;
    logic             last;
  } result_beat_t;

  logic [31:0]      gap_limit;
  logic [7:0]       start_marker;
  parse_phase_t     phase;
  logic [7:0]       held_cmd;
  logic [LEN_W-1:0] held_len;
  logic [7:0]       payload_mem [MAX_PAYLOAD];
  logic [LEN_W-1:0] fill_cnt;
  logic [7:0]       run_xor;
  logic [31:0]      last_time;
  logic             in_frame;
  result_beat_t     result_q [$];

  task automatic clear_frame();
    phase     = PH_IDLE;
    held_cmd  = '0;
    held_len  = '0;
    foreach (payload_mem[i]) payload_mem[i] = '0;
    fill_cnt  = '0;
    run_xor   = '0;
    last_time = '0;
    in_frame  = 1'b0;
  endtask

  task automatic expect_beat(input logic [1:0] st, input logic [7:0] cmd,
                             input logic [LEN_W-1:0] len, input logic [7:0] pb,
                             input logic [IDX_W-1:0] idx, input logic lst);
    result_q.push_back('{status: st, command: cmd, length: len, payload: pb,
                         index: idx, last: lst});
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic [31:0] t);
    logic [31:0] gap;
    int          k;
    gap = t - last_time;
    if (gap_limit != 0 && in_frame && gap > gap_limit) begin
      // frame aborted; the same byte is taken again from idle
      clear_frame();
      last_time = t;
      if (b == start_marker) begin
        phase    = PH_CMD;
        in_frame = 1'b1;
      end
      expect_beat(ST_TIMEOUT, '0, '0, '0, '0, 1'b1);
      return;
    end
    case (phase)
      PH_IDLE: begin
        if (b == start_marker) begin
          phase     = PH_CMD;
          in_frame  = 1'b1;
          run_xor   = '0;
          fill_cnt  = '0;
          last_time = t;
        end
      end
      PH_CMD: begin
        held_cmd  = b;
        run_xor  ^= b;
        phase     = PH_LEN;
        last_time = t;
      end
      PH_LEN: begin
        if (b > MAX_PAYLOAD) begin
          clear_frame();
        end else begin
          held_len  = b[LEN_W-1:0];
          run_xor  ^= b;
          phase     = (b == 0) ? PH_SUM : PH_DATA;
          last_time = t;
        end
      end
      PH_DATA: begin
        if (fill_cnt < MAX_PAYLOAD) payload_mem[fill_cnt[IDX_W-1:0]] = b;
        run_xor  ^= b;
        fill_cnt  = fill_cnt + 1'b1;
        if (fill_cnt >= held_len) phase = PH_SUM;
        last_time = t;
      end
      PH_SUM: begin
        last_time = t;
        if (b == run_xor) begin
          in_frame = 1'b0;
          phase    = PH_IDLE;
          if (held_len == 0) begin
            expect_beat(ST_OK, held_cmd, '0, '0, '0, 1'b1);
          end else begin
            for (k = 0; k < held_len; k++)
              expect_beat(ST_OK, held_cmd, held_len, payload_mem[k], IDX_W'(k),
                          k == held_len - 1);
          end
          return;
        end
        clear_frame();
        expect_beat(ST_SUM_ERR, '0, '0, '0, '0, 1'b1);
        return;
      end
      default: clear_frame();
    endcase
    expect_beat(ST_RECV, '0, '0, '0, '0, 1'b1);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_beat_t want;
    if (rst) begin
      gap_limit    = '0;
      start_marker = START_MARKER_RST;
      clear_frame();
      result_q.delete();
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $error("result beat with none expected: status %0d", m_tuser);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("status", want.status, m_tuser);
          check_field("frame_command", want.command, m_tdata[7:0]);
          check_field("frame_length", want.length, m_tdata[12:8]);
          check_field("payload_byte", want.payload, m_tdata[20:13]);
          check_field("payload_index", want.index, m_tdata[24:21]);
          check_field("last_of_run", want.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready) parse_byte(s_tdata[7:0], s_tdata[39:8]);
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_GAP_LIMIT:    gap_limit = cfg_data;
          REG_START_MARKER: start_marker = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    pending <= result_q.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for serial_frame_parser_timeout_top: drives byte beats, register
// writes and output backpressure, and reports the verdict from sfpt_frame_checker.
// Depends on sfpt_pkg, the design and sfpt_frame_checker.
module tb;
  import sfpt_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 4;
  localparam int STALL_LIMIT  = 2000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [39:0]          s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [31:0]          m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;
  int                   errors;
  int                   pending;

  int          tx_idle_pct;
  int          rx_stall_pct;
  bit          rx_hold_req;
  bit          rx_hold_ack;
  logic [31:0] rx_clock;
  logic [31:0] step_max;
  logic [7:0]  marker_now;
  int          items_sent;
  int          noise_sent;

  serial_frame_parser_timeout_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  sfpt_frame_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != rx_hold_ack) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_ack = rx_hold_req;
      end
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("serial_frame_parser_timeout_top test failed");
    $finish;
  end

  // mostly within the gap limit, sometimes just over it, rarely anything
  function automatic logic [31:0] next_step();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 94) return $urandom_range(step_max);
    if (r < 98) return step_max + 1 + $urandom_range(step_max);
    return $urandom;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic [31:0] dt);
    rx_clock += dt;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rx_clock, b};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic begin_phase(input logic [31:0] gap, input logic [7:0] marker,
                             input logic [31:0] step, input int idle, input int stall);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_GAP_LIMIT;
    cfg_data  <= gap;
    @(posedge clk);
    cfg_index <= REG_START_MARKER;
    cfg_data  <= {24'd0, marker};
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    marker_now   = marker;
    step_max     = step;
    tx_idle_pct  = idle;
    rx_stall_pct = stall;
    rx_clock     = $urandom;
  endtask

  task automatic send_frame();
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    logic [7:0]  cmd;
    logic [7:0]  sum;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 15) n = MAX_PAYLOAD;
    else if (pick < 75) n = $urandom_range(6);
    else n = $urandom_range(MAX_PAYLOAD);
    cmd = 8'($urandom);
    sum = cmd ^ 8'(n);
    send_byte(marker_now, next_step());
    send_byte(cmd, next_step());
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_byte(8'($urandom_range(255, MAX_PAYLOAD + 1)), next_step());
      return;
    end
    send_byte(8'(n), next_step());
    for (k = 0; k < n; k++) begin
      if (pick < 14 && k == n / 2) return;
      b = 8'($urandom);
      sum ^= b;
      send_byte(b, next_step());
    end
    if (pick >= 86) sum ^= 8'(1 << $urandom_range(7));
    send_byte(sum, next_step());
  endtask

  task automatic random_traffic(input int target);
    int base;
    base = items_sent - noise_sent;
    while (items_sent - noise_sent - base < target) begin
      if ($urandom_range(99) < 20) begin
        send_byte(8'($urandom), next_step());
        noise_sent++;
      end else begin
        send_frame();
      end
    end
  endtask

  initial begin
    logic [31:0] gap_pick;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = REG_GAP_LIMIT;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    step_max     = 32'd1;
    marker_now   = START_MARKER_RST;
    items_sent   = 0;
    noise_sent   = 0;
    rx_clock     = 32'hFFFF_FF80;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset register values: marker 0xAA, no timeout
    send_byte(8'h00, 1);
    send_byte(START_MARKER_RST, 1);
    send_byte(8'hFF, 1);
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    send_byte(START_MARKER_RST, 1);
    send_byte(8'h5A, 1);
    send_byte(8'd17, 1);
    send_byte(START_MARKER_RST, 1);
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    send_byte(START_MARKER_RST, 1);
    send_byte(8'h81, 1);
    send_byte(8'd1, 1);
    send_byte(8'h7E, 1);
    send_byte(8'h00, 1);

    // timeout cases, time wrapping through zero
    begin_phase(32'd100, 8'h3C, 32'd100, 0, 0);
    rx_clock = 32'hFFFF_FFC0;
    send_byte(8'h3C, 0);
    send_byte(8'h11, 100);
    send_byte(8'h02, 101);
    send_byte(8'h3C, 7);
    send_byte(8'h3C, 150);
    send_byte(8'h22, 3);
    send_byte(8'h00, 3);
    send_byte(8'h22, 3);

    begin_phase(32'd0, START_MARKER_RST, 32'd1000, 0, 0);
    rx_hold_req = ~rx_hold_req;
    random_traffic(40);

    begin_phase(32'hFFFF_FFFF, 8'h00, 32'd1000, 78, 0);
    random_traffic(35);

    begin_phase(32'd1, 8'hFF, 32'd1, 0, 78);
    random_traffic(20);
    drain();
    random_traffic(20);

    gap_pick = $urandom_range(500, 20);
    begin_phase(gap_pick, 8'($urandom), gap_pick, 38, 38);
    random_traffic(40);

    drain();
    if (errors == 0)
      $display("serial_frame_parser_timeout_top test passed");
    else
      $display("serial_frame_parser_timeout_top test failed");
    $finish;
  end

endmodule
